// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an immediate implication on every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a next-cycle implication on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/lcdnw_pkg.sv =====
// Types, codes and helper functions for the character LCD nibble write engine.
package lcdnw_pkg;

  localparam int unsigned CNT_W = 24;

  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_SEND_BYTE   = 2'd1;
  localparam logic [1:0] OP_SEND_NIBBLE = 2'd2;

  localparam logic [2:0] REG_SETUP       = 3'd0;
  localparam logic [2:0] REG_WRITE_PULSE = 3'd1;
  localparam logic [2:0] REG_READ_HIGH   = 3'd2;
  localparam logic [2:0] REG_READ_LOW    = 3'd3;
  localparam logic [2:0] REG_USE_BUSY    = 3'd4;
  localparam logic [2:0] REG_FIXED_WAIT  = 3'd5;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_WSETUP  = 4'd1;
  localparam logic [3:0] PH_HI_E    = 4'd2;
  localparam logic [3:0] PH_HI_GAP  = 4'd3;
  localparam logic [3:0] PH_LO_E    = 4'd4;
  localparam logic [3:0] PH_RSETUP  = 4'd5;
  localparam logic [3:0] PH_R1_HIGH = 4'd6;
  localparam logic [3:0] PH_R1_LOW  = 4'd7;
  localparam logic [3:0] PH_R2_HIGH = 4'd8;
  localparam logic [3:0] PH_R2_LOW  = 4'd9;
  localparam logic [3:0] PH_FIXED   = 4'd10;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic       register_select;
    logic       busy_pin;
  } in_item_t;

  typedef struct packed {
    logic       enable_pin;
    logic       select_pin;
    logic       read_write_pin;
    logic [3:0] data_nibble;
    logic       bus_drive;
    logic       idle;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       setup_ticks;
    logic [7:0]       write_pulse_ticks;
    logic [7:0]       read_high_ticks;
    logic [7:0]       read_low_ticks;
    logic             use_busy_flag;
    logic [CNT_W-1:0] fixed_wait_ticks;
  } cfg_t;

  function automatic logic [CNT_W-1:0] phase_len(input logic [3:0] ph, input cfg_t cfg);
    logic [CNT_W-1:0] len;
    len = CNT_W'(1);
    unique case (ph)
      PH_WSETUP, PH_RSETUP:   len = CNT_W'(cfg.setup_ticks);
      PH_HI_E, PH_LO_E:       len = CNT_W'(cfg.write_pulse_ticks);
      PH_R1_HIGH, PH_R2_HIGH: len = CNT_W'(cfg.read_high_ticks);
      PH_R1_LOW, PH_R2_LOW:   len = CNT_W'(cfg.read_low_ticks);
      PH_FIXED:               len = cfg.fixed_wait_ticks;
      default:                len = CNT_W'(1);
    endcase
    return len;
  endfunction

endpackage

// ===== src/lcdnw_if.sv =====
// Channel interfaces: send/tick requests, pin results and register writes.
interface lcdnw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       register_select;
  logic       busy_pin;

  modport source (output valid, operation, byte_value, register_select, busy_pin,
                  input ready);
  modport sink (input valid, operation, byte_value, register_select, busy_pin,
                output ready);
endinterface

interface lcdnw_out_if;
  logic       valid;
  logic       ready;
  logic       enable_pin;
  logic       select_pin;
  logic       read_write_pin;
  logic [3:0] data_nibble;
  logic       bus_drive;
  logic       idle;
  logic       rejected;

  modport source (output valid, enable_pin, select_pin, read_write_pin, data_nibble,
                  bus_drive, idle, rejected, input ready);
  modport sink (input valid, enable_pin, select_pin, read_write_pin, data_nibble,
                bus_drive, idle, rejected, output ready);
endinterface

interface lcdnw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/char_lcd_nibble_write_engine.sv =====
// Top level of the character LCD nibble write engine.
//
//  channel | dir | contents
//  in_ch   | in  | operation, byte_value, register_select, busy_pin
//  out_ch  | out | enable_pin, select_pin, read_write_pin, data_nibble, bus_drive, idle, rejected
//  cfg_ch  | in  | index, data (register writes, always ready)
//
// One request per cycle sustained while results are taken; each passes through two registers.
// An input register feeds the sequencer step, whose pin levels land in the result register.
// The input register takes a new request while the result register holds an unread result.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// A stalled result holds the sequencer and then the input register.
module char_lcd_nibble_write_engine (
  input logic          clk,
  input logic          rst_n,
  lcdnw_in_if.sink     in_ch,
  lcdnw_out_if.source  out_ch,
  lcdnw_cfg_if.sink    cfg_ch
);
  import lcdnw_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t step_result;
  cfg_t      cfg;
  logic      step_en;
  logic      in_fire;

  assign step_en = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_en;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  lcdnw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  lcdnw_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.operation       <= in_ch.operation;
      in_item_r.byte_value      <= in_ch.byte_value;
      in_item_r.register_select <= in_ch.register_select;
      in_item_r.busy_pin        <= in_ch.busy_pin;
    end
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.enable_pin     = out_item_r.enable_pin;
  assign out_ch.select_pin     = out_item_r.select_pin;
  assign out_ch.read_write_pin = out_item_r.read_write_pin;
  assign out_ch.data_nibble    = out_item_r.data_nibble;
  assign out_ch.bus_drive      = out_item_r.bus_drive;
  assign out_ch.idle           = out_item_r.idle;
  assign out_ch.rejected       = out_item_r.rejected;
endmodule

// ===== src/lcdnw_cfg_regs.sv =====
// Configuration register file with reset defaults.
module lcdnw_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [23:0]         wr_data,
  output lcdnw_pkg::cfg_t     cfg
);
  import lcdnw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_SETUP:       cfg_nxt.setup_ticks = wr_data[7:0];
        REG_WRITE_PULSE: cfg_nxt.write_pulse_ticks = wr_data[7:0];
        REG_READ_HIGH:   cfg_nxt.read_high_ticks = wr_data[7:0];
        REG_READ_LOW:    cfg_nxt.read_low_ticks = wr_data[7:0];
        REG_USE_BUSY:    cfg_nxt.use_busy_flag = wr_data[0];
        REG_FIXED_WAIT:  cfg_nxt.fixed_wait_ticks = wr_data[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks       <= 8'd14;
      cfg_r.write_pulse_ticks <= 8'd3;
      cfg_r.read_high_ticks   <= 8'd48;
      cfg_r.read_low_ticks    <= 8'd53;
      cfg_r.use_busy_flag     <= 1'b1;
      cfg_r.fixed_wait_ticks  <= 24'd1000000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== src/lcdnw_seq.sv =====
// Phase sequencer: holds the bus state and steps it once per request.
module lcdnw_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  lcdnw_pkg::in_item_t  item,
  input  lcdnw_pkg::cfg_t      cfg,
  output lcdnw_pkg::out_item_t result
);
  import lcdnw_pkg::*;

  logic [3:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             sel_r, sel_nxt;
  logic             nib_r, nib_nxt;
  logic             busy_seen_r, busy_seen_nxt;

  logic             idle_ph;
  logic             is_send;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] len;

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    byte_nxt      = byte_r;
    sel_nxt       = sel_r;
    nib_nxt       = nib_r;
    busy_seen_nxt = busy_seen_r;
    result        = '0;
    result.bus_drive = 1'b1;

    idle_ph = (phase_r == PH_IDLE) || (phase_r > PH_FIXED);
    is_send = (item.operation == OP_SEND_BYTE) || (item.operation == OP_SEND_NIBBLE);
    cnt_inc = count_r + CNT_W'(1);
    len     = phase_len(phase_r, cfg);

    if (is_send && idle_ph) begin
      nib_nxt   = (item.operation == OP_SEND_NIBBLE);
      byte_nxt  = nib_nxt ? {4'd0, item.byte_value[3:0]} : item.byte_value;
      sel_nxt   = nib_nxt ? 1'b0 : item.register_select;
      phase_nxt = PH_WSETUP;
      count_nxt = '0;
    end else begin
      result.rejected = is_send;
      if (idle_ph) begin
        phase_nxt = PH_IDLE;
        count_nxt = '0;
      end else if (cnt_inc < len) begin
        count_nxt = cnt_inc;
      end else begin
        count_nxt = '0;
        unique case (phase_r)
          PH_WSETUP:  phase_nxt = nib_r ? PH_LO_E : PH_HI_E;
          PH_HI_E:    phase_nxt = PH_HI_GAP;
          PH_HI_GAP:  phase_nxt = PH_LO_E;
          PH_LO_E:    phase_nxt = cfg.use_busy_flag ? PH_RSETUP : PH_FIXED;
          PH_RSETUP:  phase_nxt = PH_R1_HIGH;
          PH_R1_HIGH: begin
            busy_seen_nxt = item.busy_pin;
            phase_nxt     = PH_R1_LOW;
          end
          PH_R1_LOW:  phase_nxt = PH_R2_HIGH;
          PH_R2_HIGH: phase_nxt = PH_R2_LOW;
          PH_R2_LOW:  phase_nxt = busy_seen_r ? PH_R1_HIGH : PH_IDLE;
          default:    phase_nxt = PH_IDLE;
        endcase
      end
    end

    unique case (phase_nxt)
      PH_WSETUP: begin
        result.select_pin  = sel_nxt;
        result.data_nibble = nib_nxt ? byte_nxt[3:0] : byte_nxt[7:4];
      end
      PH_HI_E: begin
        result.enable_pin  = 1'b1;
        result.select_pin  = sel_nxt;
        result.data_nibble = byte_nxt[7:4];
      end
      PH_HI_GAP: begin
        result.select_pin  = sel_nxt;
        result.data_nibble = byte_nxt[7:4];
      end
      PH_LO_E: begin
        result.enable_pin  = 1'b1;
        result.select_pin  = sel_nxt;
        result.data_nibble = byte_nxt[3:0];
      end
      PH_FIXED: begin
        result.select_pin  = sel_nxt;
        result.data_nibble = byte_nxt[3:0];
      end
      PH_RSETUP, PH_R1_LOW, PH_R2_LOW: begin
        result.read_write_pin = 1'b1;
        result.bus_drive      = 1'b0;
      end
      PH_R1_HIGH, PH_R2_HIGH: begin
        result.enable_pin     = 1'b1;
        result.read_write_pin = 1'b1;
        result.bus_drive      = 1'b0;
      end
      default: begin
        result.bus_drive = 1'b1;
      end
    endcase
    result.idle = (phase_nxt == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      byte_r      <= '0;
      sel_r       <= 1'b0;
      nib_r       <= 1'b0;
      busy_seen_r <= 1'b1;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      byte_r      <= byte_nxt;
      sel_r       <= sel_nxt;
      nib_r       <= nib_nxt;
      busy_seen_r <= busy_seen_nxt;
    end
  end
endmodule

// ===== src/lcdnw_checker.sv =====
// Port-level checker for the nibble write engine, bound to the top level.
`include "assert_macros.svh"

module lcdnw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_enable_pin,
  input logic       out_select_pin,
  input logic       out_read_write_pin,
  input logic [3:0] out_data_nibble,
  input logic       out_bus_drive,
  input logic       out_idle
);
  `ASSERT_ALWAYS(a_empty_after_reset, clk, $past(!rst_n), !out_valid)
  `ASSERT_NEXT(a_stall_holds_valid, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_HOLDS(a_idle_pins, clk, rst_n, out_valid && out_idle, !out_enable_pin && !out_read_write_pin && out_bus_drive && !out_select_pin && (out_data_nibble == 4'd0))
  `ASSERT_HOLDS(a_read_releases_bus, clk, rst_n, out_valid && out_read_write_pin, !out_bus_drive && !out_select_pin && (out_data_nibble == 4'd0))
endmodule

bind char_lcd_nibble_write_engine lcdnw_checker u_lcdnw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_enable_pin     (out_ch.enable_pin),
  .out_select_pin     (out_ch.select_pin),
  .out_read_write_pin (out_ch.read_write_pin),
  .out_data_nibble    (out_ch.data_nibble),
  .out_bus_drive      (out_ch.bus_drive),
  .out_idle           (out_ch.idle)
);
